@@ hw/rtl/cid_pkg.sv @@
// ----------------------------------------------------------------------------
// cid_pkg: shared types and constants of the caller ID message parser
// Event codes, error codes, text kinds, register indexes and reset values, and
// the event record that travels from the parser front through the queue.
// ----------------------------------------------------------------------------
package cid_pkg;

	localparam logic [7:0] SEIZE_BYTE     = 8'h55;
	localparam logic [7:0] SEIZE_ALT_BYTE = 8'hD5;

	localparam int DEF_QUEUE_DEPTH = 4;

	// event codes
	localparam logic [2:0] EV_TEXT     = 3'd0;
	localparam logic [2:0] EV_DATE     = 3'd1;
	localparam logic [2:0] EV_REASON   = 3'd2;
	localparam logic [2:0] EV_CALLKIND = 3'd3;
	localparam logic [2:0] EV_COMPLETE = 3'd4;
	localparam logic [2:0] EV_ERROR    = 3'd5;

	// text kinds
	localparam logic [1:0] TK_CALLER = 2'd0;
	localparam logic [1:0] TK_CALLED = 2'd1;
	localparam logic [1:0] TK_NAME   = 2'd2;

	// error kinds
	localparam logic [1:0] ERR_FEW_SEIZE = 2'd0;
	localparam logic [1:0] ERR_BAD_TYPE  = 2'd1;
	localparam logic [1:0] ERR_EARLY_END = 2'd2;

	// register indexes
	localparam logic [2:0] REG_MIN_SEIZE  = 3'd0;
	localparam logic [2:0] REG_MSG_TYPE   = 3'd1;
	localparam logic [2:0] REG_DATE_CODE  = 3'd2;
	localparam logic [2:0] REG_CALLER     = 3'd3;
	localparam logic [2:0] REG_CALLED     = 3'd4;
	localparam logic [2:0] REG_REASON     = 3'd5;
	localparam logic [2:0] REG_NAME       = 3'd6;
	localparam logic [2:0] REG_CALL_KIND  = 3'd7;

	// register reset values
	localparam logic [7:0] RST_MIN_SEIZE = 8'd12;
	localparam logic [7:0] RST_MSG_TYPE  = 8'h80;
	localparam logic [7:0] RST_DATE_CODE = 8'd1;
	localparam logic [7:0] RST_CALLER    = 8'd2;
	localparam logic [7:0] RST_CALLED    = 8'd3;
	localparam logic [7:0] RST_REASON    = 8'd4;
	localparam logic [7:0] RST_NAME      = 8'd7;
	localparam logic [7:0] RST_CALL_KIND = 8'd17;

	typedef struct packed {
		logic [2:0] event_res;
		logic [1:0] text_kind;
		logic [7:0] value_byte;
		logic [7:0] value_index;
		logic [6:0] month;
		logic [6:0] day;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [1:0] error_kind;
	} cid_event_t;

	// up to two events per accepted byte, packed from slot 0
	typedef struct packed {
		logic [1:0] num;
		cid_event_t ev0;
		cid_event_t ev1;
	} cid_push_t;

	localparam cid_event_t EVENT_ZERO = '0;

endpackage

@@ hw/rtl/cid_front.sv @@
// ----------------------------------------------------------------------------
// cid_front: byte parser of the caller ID message
// Holds the config registers, walks seizure run, header and type-length-value
// body one byte per cycle while room is high, and hands out up to two events.
// ----------------------------------------------------------------------------
module cid_front
	import cid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_buffer,
	input  logic        room,
	output cid_push_t   push
);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_SEIZE = 3'd1;
	localparam logic [2:0] PH_LEN   = 3'd2;
	localparam logic [2:0] PH_PTYPE = 3'd3;
	localparam logic [2:0] PH_PLEN  = 3'd4;
	localparam logic [2:0] PH_PVAL  = 3'd5;
	localparam logic [2:0] PH_DRAIN = 3'd6;

	logic [7:0] min_seize_q, msg_type_q, date_code_q, caller_q;
	logic [7:0] called_q, reason_q, name_q, call_kind_q;

	logic [2:0] phase_q, phase_n;
	logic [7:0] seize_cnt_q, seize_cnt_n;
	logic [7:0] body_left_q, body_left_n;
	logic [7:0] cur_type_q, cur_type_n;
	logic [7:0] val_left_q, val_left_n;
	logic [7:0] val_pos_q, val_pos_n;
	logic [7:0] held_q, held_n;
	logic [6:0] date_q [3];
	logic [6:0] date_n [3];

	logic       accept;
	logic       a_v, b_v, c_v;
	cid_event_t a_ev, b_ev, c_ev;
	logic [6:0] pair;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic [6:0] digit_pair(input logic [7:0] a, input logic [7:0] b);
		logic [3:0] da;
		logic [3:0] db;
		da = a[3:0];
		db = b[3:0];
		if (!is_digit(a))
			return 7'd0;
		else if (!is_digit(b))
			return {3'd0, da};
		else
			return 7'({da, 3'd0}) + 7'({da, 1'b0}) + 7'(db);
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = room;
	assign accept    = in_valid && room;
	assign pair      = digit_pair(held_q, rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_seize_q <= RST_MIN_SEIZE;
			msg_type_q  <= RST_MSG_TYPE;
			date_code_q <= RST_DATE_CODE;
			caller_q    <= RST_CALLER;
			called_q    <= RST_CALLED;
			reason_q    <= RST_REASON;
			name_q      <= RST_NAME;
			call_kind_q <= RST_CALL_KIND;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_SEIZE: min_seize_q <= cfg_data;
				REG_MSG_TYPE:  msg_type_q  <= cfg_data;
				REG_DATE_CODE: date_code_q <= cfg_data;
				REG_CALLER:    caller_q    <= cfg_data;
				REG_CALLED:    called_q    <= cfg_data;
				REG_REASON:    reason_q    <= cfg_data;
				REG_NAME:      name_q      <= cfg_data;
				REG_CALL_KIND: call_kind_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_n     = phase_q;
		seize_cnt_n = seize_cnt_q;
		body_left_n = body_left_q;
		cur_type_n  = cur_type_q;
		val_left_n  = val_left_q;
		val_pos_n   = val_pos_q;
		held_n      = held_q;
		date_n      = date_q;
		a_v  = 1'b0;
		b_v  = 1'b0;
		c_v  = 1'b0;
		a_ev = EVENT_ZERO;
		b_ev = EVENT_ZERO;
		c_ev = EVENT_ZERO;

		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == SEIZE_BYTE) begin
					seize_cnt_n = 8'd1;
					phase_n     = PH_SEIZE;
				end
			end
			PH_SEIZE: begin
				if (rx_byte == SEIZE_BYTE || rx_byte == SEIZE_ALT_BYTE) begin
					if (seize_cnt_q != 8'hFF)
						seize_cnt_n = seize_cnt_q + 8'd1;
				end else if (seize_cnt_q < min_seize_q) begin
					a_v = 1'b1;
					a_ev.event_res  = EV_ERROR;
					a_ev.error_kind = ERR_FEW_SEIZE;
					phase_n = PH_DRAIN;
				end else if (rx_byte != msg_type_q) begin
					a_v = 1'b1;
					a_ev.event_res  = EV_ERROR;
					a_ev.error_kind = ERR_BAD_TYPE;
					phase_n = PH_DRAIN;
				end else begin
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				body_left_n = rx_byte;
				if (rx_byte == 8'd0) begin
					a_v = 1'b1;
					a_ev.event_res = EV_COMPLETE;
					phase_n = PH_DRAIN;
				end else begin
					phase_n = PH_PTYPE;
				end
			end
			PH_PTYPE, PH_PLEN, PH_PVAL: begin
				body_left_n = body_left_q - 8'd1;
				if (phase_q == PH_PTYPE) begin
					cur_type_n = rx_byte;
					phase_n    = PH_PLEN;
				end else if (phase_q == PH_PLEN) begin
					val_left_n = rx_byte;
					val_pos_n  = 8'd0;
					phase_n    = (rx_byte == 8'd0) ? PH_PTYPE : PH_PVAL;
				end else begin
					if (cur_type_q == date_code_q) begin
						if (val_pos_q < 8'd8) begin
							if (!val_pos_q[0]) begin
								held_n = rx_byte;
							end else if (val_pos_q < 8'd7) begin
								case (val_pos_q[2:1])
									2'd0:    date_n[0] = pair;
									2'd1:    date_n[1] = pair;
									default: date_n[2] = pair;
								endcase
							end else begin
								a_v = 1'b1;
								a_ev.event_res = EV_DATE;
								a_ev.month     = date_q[0];
								a_ev.day       = date_q[1];
								a_ev.hour      = date_q[2];
								a_ev.minute    = pair;
							end
						end
					end else if (cur_type_q == caller_q) begin
						a_v = 1'b1;
						a_ev.event_res   = EV_TEXT;
						a_ev.text_kind   = TK_CALLER;
						a_ev.value_byte  = rx_byte;
						a_ev.value_index = val_pos_q;
					end else if (cur_type_q == called_q) begin
						a_v = 1'b1;
						a_ev.event_res   = EV_TEXT;
						a_ev.text_kind   = TK_CALLED;
						a_ev.value_byte  = rx_byte;
						a_ev.value_index = val_pos_q;
					end else if (cur_type_q == reason_q) begin
						if (val_pos_q == 8'd0) begin
							a_v = 1'b1;
							a_ev.event_res  = EV_REASON;
							a_ev.value_byte = rx_byte;
						end
					end else if (cur_type_q == name_q) begin
						a_v = 1'b1;
						a_ev.event_res   = EV_TEXT;
						a_ev.text_kind   = TK_NAME;
						a_ev.value_byte  = rx_byte;
						a_ev.value_index = val_pos_q;
					end else if (cur_type_q == call_kind_q) begin
						if (val_pos_q == 8'd0) begin
							a_v = 1'b1;
							a_ev.event_res  = EV_CALLKIND;
							a_ev.value_byte = rx_byte;
						end
					end
					if (val_pos_q != 8'hFF)
						val_pos_n = val_pos_q + 8'd1;
					val_left_n = val_left_q - 8'd1;
					if (val_left_n == 8'd0)
						phase_n = PH_PTYPE;
				end
				// body length wins over a parameter that runs past it
				if (body_left_n == 8'd0) begin
					b_v = 1'b1;
					b_ev.event_res = EV_COMPLETE;
					phase_n = PH_DRAIN;
				end
			end
			default: ;
		endcase

		if (end_of_buffer) begin
			if (phase_n != PH_DRAIN) begin
				c_v = 1'b1;
				c_ev.event_res = EV_ERROR;
				if ((phase_n == PH_HUNT || phase_n == PH_SEIZE) && seize_cnt_n < min_seize_q)
					c_ev.error_kind = ERR_FEW_SEIZE;
				else
					c_ev.error_kind = ERR_EARLY_END;
			end
			phase_n     = PH_HUNT;
			seize_cnt_n = 8'd0;
			body_left_n = 8'd0;
			cur_type_n  = 8'd0;
			val_left_n  = 8'd0;
			val_pos_n   = 8'd0;
			held_n      = 8'd0;
			date_n[0]   = 7'd0;
			date_n[1]   = 7'd0;
			date_n[2]   = 7'd0;
		end
	end

	// pack the events from slot 0, in order
	always_comb begin
		push.num = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
		if (!accept)
			push.num = 2'd0;
		push.ev0 = a_v ? a_ev : (b_v ? b_ev : c_ev);
		push.ev1 = (a_v && b_v) ? b_ev : c_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			seize_cnt_q <= 8'd0;
			body_left_q <= 8'd0;
			cur_type_q  <= 8'd0;
			val_left_q  <= 8'd0;
			val_pos_q   <= 8'd0;
			held_q      <= 8'd0;
			date_q[0]   <= 7'd0;
			date_q[1]   <= 7'd0;
			date_q[2]   <= 7'd0;
		end else if (accept) begin
			phase_q     <= phase_n;
			seize_cnt_q <= seize_cnt_n;
			body_left_q <= body_left_n;
			cur_type_q  <= cur_type_n;
			val_left_q  <= val_left_n;
			val_pos_q   <= val_pos_n;
			held_q      <= held_n;
			date_q      <= date_n;
		end
	end

endmodule

@@ hw/rtl/cid_queue.sv @@
// ----------------------------------------------------------------------------
// cid_queue: event queue between parser and output stage
// Takes up to two events a cycle, gives one a cycle while pop is high; offers
// room while at least two entries are free.
// ----------------------------------------------------------------------------
module cid_queue
	import cid_pkg::*;
#(
	parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  cid_push_t  push,
	output logic       room,
	input  logic       pop,
	output logic       head_valid,
	output cid_event_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	cid_event_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	// wrap at the last entry so depths that are not a power of two work
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_ptr_nx  = ptr_inc(wr_ptr_q);
	assign room       = count_q <= CNT_W'(DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.num != 2'd0)
			mem_q[wr_ptr_q] <= push.ev0;
		if (push.num == 2'd2)
			mem_q[wr_ptr_nx] <= push.ev1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.num == 2'd2)
				wr_ptr_q <= ptr_inc(wr_ptr_nx);
			else if (push.num == 2'd1)
				wr_ptr_q <= wr_ptr_nx;
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q <= count_q + CNT_W'(push.num) - CNT_W'(do_pop);
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("event queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.num != 2'd0 |-> room)
		else $error("events pushed without room");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty event queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push.num == 2'd0 && !do_pop |=> $stable(count_q))
		else $error("queue count moved without push or pop");
`endif

endmodule

@@ hw/rtl/cid_back.sv @@
// ----------------------------------------------------------------------------
// cid_back: result output stage
// Pulls events from the queue into the output register and holds each one
// until the consumer takes it.
// ----------------------------------------------------------------------------
module cid_back
	import cid_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cid_event_t head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output cid_event_t out_ev
);

	logic       out_valid_q;
	cid_event_t out_q;

	// advance when the register is empty or being taken
	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_ev    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= head;
	end

endmodule

@@ hw/rtl/caller_id_message_parser.sv @@
// ----------------------------------------------------------------------------
// caller_id_message_parser: caller ID message parser, top level
// Parses received caller ID bytes into text, date, reason, call type,
// completion and error events.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready   | rx_byte, end_of_buffer
//   out     | output    | out_valid / out_ready | event_res .. error_kind
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte is taken per cycle while in_ready is high; each byte yields zero
// to two events, which pass through the event queue into the output register.
// The output gives one event per cycle while out_ready is high, so a burst of
// two-event bytes fills the QUEUE_DEPTH-entry event queue and in_ready drops
// until it drains. in_ready is low while fewer than two queue entries are free.
// Reset clears the parse state, loads the register defaults and empties
// the queue; cfg_ready is always high.
// ----------------------------------------------------------------------------
module caller_id_message_parser
	import cid_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       end_of_buffer,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_res,
	output logic [1:0] text_kind,
	output logic [7:0] value_byte,
	output logic [7:0] value_index,
	output logic [6:0] month,
	output logic [6:0] day,
	output logic [6:0] hour,
	output logic [6:0] minute,
	output logic [1:0] error_kind
);

	cid_push_t  push;
	logic       room;
	logic       pop;
	logic       head_valid;
	cid_event_t head;
	cid_event_t out_ev;

	cid_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.end_of_buffer (end_of_buffer),
		.room          (room),
		.push          (push)
	);

	cid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	cid_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_ev     (out_ev)
	);

	assign event_res   = out_ev.event_res;
	assign text_kind   = out_ev.text_kind;
	assign value_byte  = out_ev.value_byte;
	assign value_index = out_ev.value_index;
	assign month       = out_ev.month;
	assign day         = out_ev.day;
	assign hour        = out_ev.hour;
	assign minute      = out_ev.minute;
	assign error_kind  = out_ev.error_kind;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the caller ID message parser
// Feeds directed and random caller ID buffers through the byte channel with
// random source gaps and sink stalls. A behavioral parser tracks the same
// registers and parse state and queues the events each accepted byte causes;
// every event that leaves the block is matched field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import cid_pkg::*;

	typedef enum logic [2:0] {
		PS_HUNT, PS_SEIZE, PS_LEN, PS_PTYPE, PS_PLEN, PS_PVAL, PS_DRAIN
	} parse_phase_e;

	typedef enum logic {ROW_RX, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e  kind;
		logic [2:0] idx;
		logic [7:0] data;
		logic       eob;
		logic       typed;
		cid_event_t ev;
	} step_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = '0;
	logic       end_of_buffer = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] event_res;
	logic [1:0] text_kind;
	logic [7:0] value_byte;
	logic [7:0] value_index;
	logic [6:0] month;
	logic [6:0] day;
	logic [6:0] hour;
	logic [6:0] minute;
	logic [1:0] error_kind;

	caller_id_message_parser dut (.*);

	// parser copy: registers and parse state
	logic [7:0] cfg_reg [8] = '{RST_MIN_SEIZE, RST_MSG_TYPE, RST_DATE_CODE, RST_CALLER,
		RST_CALLED, RST_REASON, RST_NAME, RST_CALL_KIND};
	parse_phase_e ps = PS_HUNT;
	logic [7:0] seize_cnt = '0;
	logic [7:0] body_left = '0;
	logic [7:0] cur_type = '0;
	logic [7:0] val_left = '0;
	logic [7:0] val_pos = '0;
	logic [7:0] held_digit = '0;
	logic [6:0] date_pair [3] = '{7'd0, 7'd0, 7'd0};

	cid_event_t events_due[$];
	cid_event_t want;
	step_t      script[$];
	logic [7:0] frame[$];
	int         mismatches = 0;
	int         gap_pct = 30;
	int         stall_pct = 30;
	int         stall_left = 0;
	bit         quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic cid_event_t status_ev(input logic [2:0] ev, input logic [1:0] ek);
		cid_event_t r;
		r = EVENT_ZERO;
		r.event_res = ev;
		r.error_kind = ek;
		return r;
	endfunction

	function automatic cid_event_t value_ev(input logic [2:0] ev, input logic [1:0] tk,
		input logic [7:0] vb, input logic [7:0] vi);
		cid_event_t r;
		r = EVENT_ZERO;
		r.event_res = ev;
		r.text_kind = tk;
		r.value_byte = vb;
		r.value_index = vi;
		return r;
	endfunction

	// a non-digit first character reads as zero, a non-digit second one is dropped
	function automatic logic [6:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
		if (!(hi inside {[8'h30:8'h39]}))
			return '0;
		if (!(lo inside {[8'h30:8'h39]}))
			return 7'(hi - 8'h30);
		return 7'((hi - 8'h30) * 10 + (lo - 8'h30));
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b, input logic e);
		cid_event_t dt;
		logic [1:0] why;
		case (ps)
		PS_HUNT: if (b == SEIZE_BYTE) begin
			seize_cnt = 8'd1;
			ps = PS_SEIZE;
		end
		PS_SEIZE: begin
			if (b == SEIZE_BYTE || b == SEIZE_ALT_BYTE) begin
				if (seize_cnt != 8'hFF)
					seize_cnt++;
			end else if (seize_cnt < cfg_reg[REG_MIN_SEIZE]) begin
				events_due.push_back(status_ev(EV_ERROR, ERR_FEW_SEIZE));
				ps = PS_DRAIN;
			end else if (b != cfg_reg[REG_MSG_TYPE]) begin
				events_due.push_back(status_ev(EV_ERROR, ERR_BAD_TYPE));
				ps = PS_DRAIN;
			end else begin
				ps = PS_LEN;
			end
		end
		PS_LEN: begin
			body_left = b;
			if (b == 8'd0) begin
				events_due.push_back(status_ev(EV_COMPLETE, '0));
				ps = PS_DRAIN;
			end else begin
				ps = PS_PTYPE;
			end
		end
		PS_PTYPE, PS_PLEN, PS_PVAL: begin
			body_left--;
			if (ps == PS_PTYPE) begin
				cur_type = b;
				ps = PS_PLEN;
			end else if (ps == PS_PLEN) begin
				val_left = b;
				val_pos = '0;
				ps = (b == 8'd0) ? PS_PTYPE : PS_PVAL;
			end else begin
				// earlier matching code wins when codes coincide
				if (cur_type == cfg_reg[REG_DATE_CODE]) begin
					if (val_pos < 8'd8) begin
						if (!val_pos[0]) begin
							held_digit = b;
						end else if (val_pos == 8'd7) begin
							dt = status_ev(EV_DATE, '0);
							dt.month = date_pair[0];
							dt.day = date_pair[1];
							dt.hour = date_pair[2];
							dt.minute = pair_value(held_digit, b);
							events_due.push_back(dt);
						end else begin
							date_pair[val_pos[2:1]] = pair_value(held_digit, b);
						end
					end
				end else if (cur_type == cfg_reg[REG_CALLER]) begin
					events_due.push_back(value_ev(EV_TEXT, TK_CALLER, b, val_pos));
				end else if (cur_type == cfg_reg[REG_CALLED]) begin
					events_due.push_back(value_ev(EV_TEXT, TK_CALLED, b, val_pos));
				end else if (cur_type == cfg_reg[REG_REASON]) begin
					if (val_pos == 8'd0)
						events_due.push_back(value_ev(EV_REASON, '0, b, '0));
				end else if (cur_type == cfg_reg[REG_NAME]) begin
					events_due.push_back(value_ev(EV_TEXT, TK_NAME, b, val_pos));
				end else if (cur_type == cfg_reg[REG_CALL_KIND]) begin
					if (val_pos == 8'd0)
						events_due.push_back(value_ev(EV_CALLKIND, '0, b, '0));
				end
				if (val_pos != 8'hFF)
					val_pos++;
				val_left--;
				if (val_left == 8'd0)
					ps = PS_PTYPE;
			end
			// body length wins over any parameter still open
			if (body_left == 8'd0) begin
				events_due.push_back(status_ev(EV_COMPLETE, '0));
				ps = PS_DRAIN;
			end
		end
		default: ;
		endcase
		if (e) begin
			if (ps != PS_DRAIN) begin
				why = ERR_EARLY_END;
				if ((ps == PS_HUNT || ps == PS_SEIZE) && seize_cnt < cfg_reg[REG_MIN_SEIZE])
					why = ERR_FEW_SEIZE;
				events_due.push_back(status_ev(EV_ERROR, why));
			end
			ps = PS_HUNT;
			seize_cnt = '0;
			body_left = '0;
			cur_type = '0;
			val_left = '0;
			val_pos = '0;
			held_digit = '0;
			date_pair = '{7'd0, 7'd0, 7'd0};
		end
	endtask

	function automatic step_t rx(input logic [7:0] b, input logic e);
		step_t r;
		r = '0;
		r.kind = ROW_RX;
		r.data = b;
		r.eob = e;
		return r;
	endfunction

	function automatic step_t rx_want(input logic [7:0] b, input logic e, input cid_event_t ev);
		step_t r;
		r = rx(b, e);
		r.typed = 1'b1;
		r.ev = ev;
		return r;
	endfunction

	function automatic step_t reg_write(input logic [2:0] idx, input logic [7:0] v);
		step_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = v;
		return r;
	endfunction

	// present one byte request; a typed row replaces what the parser copy queued
	task automatic send_rx(input logic [7:0] b, input logic e, input logic typed,
		input cid_event_t ev);
		int n0;
		in_valid <= 1'b1;
		rx_byte <= b;
		end_of_buffer <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n0 = events_due.size();
		parse_rx_byte(b, e);
		if (typed) begin
			while (events_due.size() > n0)
				void'(events_due.pop_back());
			events_due.push_back(ev);
		end
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_reg[idx] = v;
	endtask

	// drain all events, then let any byte with no event clear the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic apply_setting(input int p);
		logic [7:0] vals [8];
		logic [7:0] x;
		vals = '{RST_MIN_SEIZE, RST_MSG_TYPE, RST_DATE_CODE, RST_CALLER,
			RST_CALLED, RST_REASON, RST_NAME, RST_CALL_KIND};
		x = 8'($urandom_range(0, 255));
		case (p)
		0: vals[REG_MIN_SEIZE] = 8'd1;
		1: ;
		2: begin
			vals[REG_MIN_SEIZE] = 8'd255;
			vals[REG_MSG_TYPE] = 8'h00;
			vals[REG_DATE_CODE] = 8'h00;
			vals[REG_CALLER] = 8'hFF;
		end
		3: begin
			// pairs of equal codes: the earlier one in the lookup order wins
			vals[REG_MIN_SEIZE] = 8'($urandom_range(1, 4));
			vals[REG_MSG_TYPE] = (x == SEIZE_BYTE || x == SEIZE_ALT_BYTE) ? RST_MSG_TYPE : x;
			vals[REG_DATE_CODE] = x;
			vals[REG_CALLER] = x;
			vals[REG_CALLED] = x + 8'd1;
			vals[REG_NAME] = x + 8'd1;
			vals[REG_REASON] = x + 8'd2;
			vals[REG_CALL_KIND] = x + 8'd2;
		end
		default: begin
			vals[REG_MIN_SEIZE] = 8'($urandom_range(1, 6));
			vals[REG_MSG_TYPE] = 8'hFF;
			for (int i = REG_DATE_CODE; i <= REG_CALL_KIND; i++)
				vals[i] = 8'($urandom_range(0, 255));
		end
		endcase
		settle();
		for (int i = REG_MIN_SEIZE; i <= REG_CALL_KIND; i++)
			write_reg(3'(i), vals[i]);
		cfg_valid <= 1'b0;
	endtask

	// one buffer: mostly well-formed messages with random content
	task automatic build_buffer(input bit first);
		int n_seize, n_par, k, plen, body, len, cut;
		logic [7:0] ptype;
		logic [7:0] body_bytes[$];
		frame.delete();
		if (!first && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 16))
				frame.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 3))
			frame.push_back(8'($urandom_range(0, 255)));
		if (cfg_reg[REG_MIN_SEIZE] > 8'd20)
			n_seize = first ? 256 + $urandom_range(0, 3) : $urandom_range(1, 8);
		else if ($urandom_range(0, 9) == 0)
			n_seize = cfg_reg[REG_MIN_SEIZE] - 1;
		else
			n_seize = cfg_reg[REG_MIN_SEIZE] + $urandom_range(0, 3);
		for (int i = 0; i < n_seize; i++)
			frame.push_back((i == 0 || $urandom_range(0, 1)) ? SEIZE_BYTE : SEIZE_ALT_BYTE);
		frame.push_back(($urandom_range(0, 9) != 0) ? cfg_reg[REG_MSG_TYPE] :
			8'($urandom_range(0, 255)));
		n_par = $urandom_range(0, 4);
		repeat (n_par) begin
			k = $urandom_range(0, 7);
			ptype = (k < 6) ? cfg_reg[REG_DATE_CODE + k] : 8'($urandom_range(0, 255));
			case (k)
			0: plen = ($urandom_range(0, 4) != 0) ? 8 : $urandom_range(0, 10);
			1, 2, 4: plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) :
				$urandom_range(0, 12);
			3, 5: plen = $urandom_range(0, 2);
			default: plen = $urandom_range(0, 4);
			endcase
			body_bytes.push_back(ptype);
			body_bytes.push_back(8'(plen));
			repeat (plen)
				body_bytes.push_back((k == 0 && $urandom_range(0, 7) != 0) ?
					8'(8'h30 + $urandom_range(0, 9)) : 8'($urandom_range(0, 255)));
		end
		body = body_bytes.size();
		case ($urandom_range(0, 19))
		0: len = 0;
		1, 2: len = (body > 0) ? $urandom_range(1, body) : 0;
		3: len = body + $urandom_range(1, 3);
		default: len = body;
		endcase
		frame.push_back(8'(len));
		foreach (body_bytes[i])
			frame.push_back(body_bytes[i]);
		// a random checksum byte, then up to two trailing bytes
		repeat ($urandom_range(1, 3))
			frame.push_back(8'($urandom_range(0, 255)));
		if (!first && $urandom_range(0, 11) == 0) begin
			cut = $urandom_range(1, frame.size());
			while (frame.size() > cut)
				void'(frame.pop_back());
		end
	endtask

	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// sink: stall in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (events_due.size() == 0) begin
				$display("%0t: event_res expected none, actual %0d", $time, event_res);
				mismatches++;
			end else begin
				want = events_due.pop_front();
				check_field("event_res", want.event_res, event_res);
				check_field("text_kind", want.text_kind, text_kind);
				check_field("value_byte", want.value_byte, value_byte);
				check_field("value_index", want.value_index, value_index);
				check_field("month", want.month, month);
				check_field("day", want.day, day);
				check_field("hour", want.hour, hour);
				check_field("minute", want.minute, minute);
				check_field("error_kind", want.error_kind, error_kind);
			end
		end
	end

	initial begin
		step_t row;
		int sent, budget;
		bit first;

		// defaults: twelve seizure bytes needed
		script.push_back(rx_want(8'h00, 1'b1, status_ev(EV_ERROR, ERR_FEW_SEIZE)));
		script.push_back(rx(8'h55, 1'b0));
		script.push_back(rx_want(8'h07, 1'b0, status_ev(EV_ERROR, ERR_FEW_SEIZE)));
		script.push_back(rx(8'hFF, 1'b1));
		script.push_back(reg_write(REG_MIN_SEIZE, 8'd1));
		script.push_back(rx(8'h55, 1'b0));
		script.push_back(rx(8'hD5, 1'b0));
		script.push_back(rx_want(8'h81, 1'b0, status_ev(EV_ERROR, ERR_BAD_TYPE)));
		script.push_back(rx(8'h00, 1'b1));
		// empty body completes on the length byte
		script.push_back(rx(8'h55, 1'b0));
		script.push_back(rx(8'h80, 1'b0));
		script.push_back(rx_want(8'h00, 1'b0, status_ev(EV_COMPLETE, '0)));
		script.push_back(rx(8'h11, 1'b1));
		// date 12/31 09:00 with odd digits, caller byte, then an early end
		script.push_back(rx(8'h55, 1'b0));
		script.push_back(rx(8'h80, 1'b0));
		script.push_back(rx(8'hFF, 1'b0));
		script.push_back(rx(RST_DATE_CODE, 1'b0));
		script.push_back(rx(8'd8, 1'b0));
		script.push_back(rx(8'h31, 1'b0));
		script.push_back(rx(8'h32, 1'b0));
		script.push_back(rx(8'h33, 1'b0));
		script.push_back(rx(8'h31, 1'b0));
		script.push_back(rx(8'h39, 1'b0));
		script.push_back(rx(8'h78, 1'b0));
		script.push_back(rx(8'h41, 1'b0));
		script.push_back(rx(8'h35, 1'b0));
		script.push_back(rx(RST_CALLER, 1'b0));
		script.push_back(rx(8'd1, 1'b0));
		script.push_back(rx_want(8'hFF, 1'b0, value_ev(EV_TEXT, TK_CALLER, 8'hFF, 8'h00)));
		script.push_back(rx_want(8'h00, 1'b1, status_ev(EV_ERROR, ERR_EARLY_END)));

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_CFG) begin
				settle();
				write_reg(row.idx, row.data);
				cfg_valid <= 1'b0;
			end else begin
				send_rx(row.data, row.eob, row.typed, row.ev);
			end
		end

		for (int p = 0; p < 5; p++) begin
			apply_setting(p);
			quiet = (p == 4);
			gap_pct = 20 * $urandom_range(0, 2);
			stall_pct = 20 * $urandom_range(0, 2);
			budget = (p == 2) ? 240 : 50;
			sent = 0;
			first = 1'b1;
			while (sent < budget) begin
				build_buffer(first);
				first = 1'b0;
				foreach (frame[i])
					send_rx(frame[i], i == frame.size() - 1, 1'b0, EVENT_ZERO);
				sent += frame.size();
			end
		end

		in_valid <= 1'b0;
		while (events_due.size() != 0)
			@(posedge clk);
		repeat (16)
			@(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ caller_id_message_parser.f @@
hw/rtl/cid_pkg.sv
hw/rtl/cid_front.sv
hw/rtl/cid_queue.sv
hw/rtl/cid_back.sv
hw/rtl/caller_id_message_parser.sv
sim/tb_top.sv
